/* rtl/lsd_pkg.sv */
// lifo stack with dump: shared types and constants
// used by lsd_ctrl, lsd_dpath and lifo_stack_with_dump
package lsd_pkg;

  localparam int DEPTH = 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DUMP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_PUSH,
    SRC_MEM,
    SRC_ZERO
  } src_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    wr;
    logic    inc;
    logic    dec;
    logic    rd_start;
    logic    rd_next;
    logic    load_out;
    src_t    out_src;
    status_t out_status;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic ptr_zero;
  } stat_t;

endpackage

/* rtl/lsd_dpath.sv */
// lifo stack with dump: entry memory, entry count, read pointer and output word register
// depends on lsd_pkg
module lsd_dpath import lsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic signed [DW-1:0] push_value,
  output stat_t                stat,
  output logic signed [DW-1:0] data_value,
  output status_t              status,
  output logic                 now_empty,
  output logic                 now_full,
  output logic                 last_of_run
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] out_data_nxt;

  logic signed [DW-1:0] out_data_r;
  status_t              out_status_r;
  logic                 out_empty_r;
  logic                 out_full_r;
  logic                 out_last_r;

  assign count_m1 = count_r - CW'(1);

  always_comb begin
    count_nxt = count_r;
    if (cmd.inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.dec) begin
      count_nxt = count_m1;
    end
    ptr_nxt = ptr_r;
    rd_addr = ptr_r - AW'(1);
    if (cmd.rd_start) begin
      rd_addr = count_m1[AW-1:0];
      ptr_nxt = count_m1[AW-1:0];
    end else if (cmd.rd_next) begin
      ptr_nxt = rd_addr;
    end
    case (cmd.out_src)
      SRC_PUSH: out_data_nxt = push_value;
      SRC_MEM:  out_data_nxt = rdata_r;
      default:  out_data_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[count_r[AW-1:0]] <= push_value;
    end
    if (cmd.rd_start || cmd.rd_next) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load_out) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= cmd.out_status;
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == CW'(DEPTH));
      out_last_r   <= cmd.out_last;
    end
  end

  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CW'(DEPTH));
  assign stat.ptr_zero = (ptr_r == '0);

  assign data_value  = out_data_r;
  assign status      = out_status_r;
  assign now_empty   = out_empty_r;
  assign now_full    = out_full_r;
  assign last_of_run = out_last_r;

endmodule

/* rtl/lsd_ctrl.sv */
// lifo stack with dump: operation sequencer driving the datapath
// depends on lsd_pkg
module lsd_ctrl import lsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       out_last,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   dump_r, dump_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dump_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dump_r  <= dump_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    dump_nxt       = dump_r;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.out_src    = SRC_ZERO;
    cmd.out_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid) begin
          case (op_t'(in_op))
            OP_PUSH: begin
              cmd.load_out = 1'b1;
              cmd.out_last = 1'b1;
              state_nxt    = S_OUT;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.wr      = 1'b1;
                cmd.inc     = 1'b1;
                cmd.out_src = SRC_PUSH;
              end
            end
            OP_POP, OP_DUMP: begin
              dump_nxt = (op_t'(in_op) == OP_DUMP);
              if (stat.empty) begin
                cmd.load_out   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
                state_nxt      = S_OUT;
              end else begin
                cmd.rd_start = 1'b1;
                cmd.dec      = (op_t'(in_op) == OP_POP);
                state_nxt    = S_READ;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.load_out = 1'b1;
        cmd.out_src  = SRC_MEM;
        cmd.out_last = !dump_r || stat.ptr_zero;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/lifo_stack_with_dump.sv */
// lifo stack with dump: top level joining sequencer and datapath
// depends on lsd_pkg, lsd_ctrl, lsd_dpath
//
//   channel  dir  handshake              tdata        tuser                    tlast
//   in_      in   in_tvalid/in_tready    push_value   opcode                   -
//   out_     out  out_tvalid/out_tready  data_value   status, empty, full      last_of_run
//
// push, and pop or dump on an empty stack: result word in the cycle after acceptance
// pop: word goes via the memory read register to the output register; dump: likewise per entry
// input held off until the last word goes; opcode 3 is accepted and gives no word
// reset clears the entry count and sequencer; the entry memory needs no clearing
// a stalled output word holds in the output register and the sequencer waits
module lifo_stack_with_dump import lsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data_value
  output logic [3:0]  out_tuser,  // [1:0] status, [2] now_empty, [3] now_full
  output logic        out_tlast   // last_of_run
);

  cmd_t    cmd;
  stat_t   stat;
  status_t status;
  logic    now_empty;
  logic    now_full;

  lsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_last  (out_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsd_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .push_value  (in_tdata),
    .stat        (stat),
    .data_value  (out_tdata),
    .status      (status),
    .now_empty   (now_empty),
    .now_full    (now_full),
    .last_of_run (out_tlast)
  );

  assign out_tuser = {now_full, now_empty, status};

endmodule
